@@ design/tsep_pkg.sv @@
`default_nettype none

package tsep_pkg;

    // result status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_MALFORMED = 2'd1;
    localparam logic [1:0] STATUS_BAD_DATE  = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic take_char;   // a character item is accepted this cycle
        logic calc_fields; // range checks, year and day counts
        logic calc_prods;  // the four products
        logic load_out;    // final sum into the output register
    } tsep_cmd_t;

endpackage

`default_nettype wire

@@ design/tsep_ctrl.sv @@
`default_nettype none

module tsep_ctrl
    import tsep_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    input  wire logic s_is_last,
    output logic      s_ready,
    output logic      m_valid,
    input  wire logic m_ready,
    output tsep_cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_RECV   = 4'b0001,
        ST_FIELDS = 4'b0010,
        ST_PRODS  = 4'b0100,
        ST_SUM    = 4'b1000
    } tsep_state_t;

    tsep_state_t state_reg, state_next;
    logic        out_full_reg, out_full_next;

    // a final character waits until the output register is free
    assign s_ready = (state_reg == ST_RECV) && (!out_full_reg || !s_is_last);
    assign m_valid = out_full_reg;

    always_comb begin
        cmd.take_char   = s_valid && s_ready;
        cmd.calc_fields = (state_reg == ST_FIELDS);
        cmd.calc_prods  = (state_reg == ST_PRODS);
        cmd.load_out    = (state_reg == ST_SUM);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_RECV: begin
                if (s_valid && s_ready && s_is_last) begin
                    state_next = ST_FIELDS;
                end
            end
            ST_FIELDS: state_next = ST_PRODS;
            ST_PRODS:  state_next = ST_SUM;
            ST_SUM:    state_next = ST_RECV;
            default:   state_next = ST_RECV;
        endcase
    end

    always_comb begin
        out_full_next = out_full_reg;
        if (out_full_reg && m_ready) begin
            out_full_next = 1'b0;
        end
        if (state_reg == ST_SUM) begin
            out_full_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_RECV;
            out_full_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            out_full_reg <= out_full_next;
        end
    end

endmodule

`default_nettype wire

@@ design/tsep_dp.sv @@
`default_nettype none

module tsep_dp
    import tsep_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire tsep_cmd_t   cmd,
    input  wire logic [7:0]  s_char_code,
    input  wire logic        s_is_last,
    output logic [31:0]      m_epoch_seconds,
    output logic [1:0]       m_status
);

    localparam logic [31:0] SecPerYear = 32'd31536000;
    localparam logic [31:0] SecPerDay  = 32'd86400;
    localparam logic [16:0] SecPerHour = 17'd3600;
    localparam logic [11:0] SecPerMin  = 12'd60;
    localparam logic [3:0]  PosLast    = 4'd12;
    localparam logic [3:0]  PosSat     = 4'd15;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c inside {8'h20, [8'h09:8'h0D]};
    endfunction

    // atoi over two characters, 8-bit two's complement
    function automatic logic [7:0] read_pair(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] da;
        logic [7:0] db;
        da = {4'b0, a[3:0]};
        db = {4'b0, b[3:0]};
        if (is_digit(a)) begin
            if (is_digit(b)) begin
                return 8'(da * 8'd10) + db;
            end
            return da;
        end
        if ((is_blank(a) || a == 8'h2B) && is_digit(b)) begin
            return db;
        end
        if (a == 8'h2D && is_digit(b)) begin
            return 8'd0 - db;
        end
        return 8'd0;
    endfunction

    function automatic logic [8:0] days_before(input logic [7:0] mo);
        case (mo)
            8'd1:    return 9'd0;
            8'd2:    return 9'd31;
            8'd3:    return 9'd59;
            8'd4:    return 9'd90;
            8'd5:    return 9'd120;
            8'd6:    return 9'd151;
            8'd7:    return 9'd181;
            8'd8:    return 9'd212;
            8'd9:    return 9'd243;
            8'd10:   return 9'd273;
            8'd11:   return 9'd304;
            8'd12:   return 9'd334;
            default: return 9'd0;
        endcase
    endfunction

    function automatic logic [4:0] month_len(input logic [7:0] mo, input logic leap);
        case (mo)
            8'd2:                      return leap ? 5'd29 : 5'd28;
            8'd4, 8'd6, 8'd9, 8'd11:   return 5'd30;
            default:                   return 5'd31;
        endcase
    endfunction

    // parser state
    logic [3:0] pos_reg;
    logic       sep_reg;
    logic [7:0] first_reg;
    logic [7:0] year_reg, month_reg, day_reg, hour_reg, minute_reg;
    logic       pos_ok_reg;

    // first stage
    logic [6:0] nyrs_reg;
    logic [8:0] days_reg;
    logic [4:0] hr_reg;
    logic [5:0] mn_reg;
    logic [1:0] status1_reg;

    // second stage
    logic [31:0] py_reg, pd_reg;
    logic [16:0] ph_reg;
    logic [11:0] pm_reg;
    logic [1:0]  status2_reg;

    // output register
    logic [31:0] secs_out_reg;
    logic [1:0]  status_out_reg;

    assign m_epoch_seconds = secs_out_reg;
    assign m_status        = status_out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            sep_reg <= 1'b0;
        end else if (cmd.take_char) begin
            if (s_is_last) begin
                pos_reg <= '0;
                sep_reg <= 1'b0;
            end else begin
                if (pos_reg != PosSat) begin
                    pos_reg <= pos_reg + 4'd1;
                end
                if (pos_reg == 4'd8) begin
                    sep_reg <= (s_char_code == 8'h5F);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take_char) begin
            case (pos_reg)
                4'd2, 4'd4, 4'd6, 4'd9, 4'd11: first_reg <= s_char_code;
                4'd3:  year_reg  <= read_pair(first_reg, s_char_code);
                4'd5:  month_reg <= read_pair(first_reg, s_char_code);
                4'd7:  day_reg   <= read_pair(first_reg, s_char_code);
                4'd10: hour_reg  <= read_pair(first_reg, s_char_code);
                default: ;
            endcase
            if (s_is_last) begin
                minute_reg <= read_pair(first_reg, s_char_code);
                pos_ok_reg <= (pos_reg == PosLast) && sep_reg;
            end
        end
    end

    // field checks and day count
    logic       yr_ok, mo_ok, dy_ok, hr_ok, mn_ok, leap, late_century;
    logic [4:0] nleap;
    logic [6:0] nyrs;
    logic [8:0] days;

    always_comb begin
        late_century = (year_reg >= 8'd70);
        leap  = (year_reg[1:0] == 2'b00);
        yr_ok = !year_reg[7] && (year_reg <= 8'd99);
        mo_ok = (month_reg >= 8'd1) && (month_reg <= 8'd12);
        dy_ok = !day_reg[7] && (day_reg != 8'd0)
                && (day_reg <= {3'b0, month_len(month_reg, leap)});
        hr_ok = !hour_reg[7] && (hour_reg <= 8'd23);
        mn_ok = !minute_reg[7] && (minute_reg <= 8'd59);
        if (late_century) begin
            nyrs  = year_reg[6:0] - 7'd70;
            nleap = 5'((year_reg[6:0] - 7'd68) >> 2);
        end else begin
            nyrs  = year_reg[6:0] + 7'd30;
            nleap = 5'((year_reg[6:0] + 7'd4) >> 2) + 5'd7;
        end
        days = 9'(nleap) + days_before(month_reg) + 9'(day_reg[4:0]) - 9'd1
               - 9'(leap && (month_reg <= 8'd2));
    end

    always_ff @(posedge aclk) begin
        if (cmd.calc_fields) begin
            nyrs_reg <= nyrs;
            days_reg <= days;
            hr_reg   <= hour_reg[4:0];
            mn_reg   <= minute_reg[5:0];
            if (!pos_ok_reg) begin
                status1_reg <= STATUS_MALFORMED;
            end else if (!(yr_ok && mo_ok && dy_ok && hr_ok && mn_ok)) begin
                status1_reg <= STATUS_BAD_DATE;
            end else begin
                status1_reg <= STATUS_OK;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.calc_prods) begin
            py_reg      <= 32'(nyrs_reg) * SecPerYear;
            pd_reg      <= 32'(days_reg) * SecPerDay;
            ph_reg      <= 17'(hr_reg) * SecPerHour;
            pm_reg      <= 12'(mn_reg) * SecPerMin;
            status2_reg <= status1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            status_out_reg <= status2_reg;
            if (status2_reg == STATUS_OK) begin
                secs_out_reg <= py_reg + pd_reg + 32'(ph_reg) + 32'(pm_reg);
            end else begin
                secs_out_reg <= '0;
            end
        end
    end

endmodule

`default_nettype wire

@@ design/timestamp_name_to_epoch_seconds.sv @@
`default_nettype none

// channel  dir  handshake          payload
// s_       in   s_valid/s_ready    s_char_code[7:0], s_is_last
// m_       out  m_valid/m_ready    m_epoch_seconds[31:0], m_status[1:0]
//
// one character item per cycle while the block is receiving; after the final
// character the block steps through the check, multiply and sum stages before
// the result is registered, and takes no new character until the sum is done.
// a final character is held off while the previous result is still untaken.
// aresetn is synchronous, active low, and returns the parser to position 0.

module timestamp_name_to_epoch_seconds
    import tsep_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_char_code,
    input  wire logic        s_is_last,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_epoch_seconds,
    output logic [1:0]       m_status
);

    tsep_cmd_t cmd;

    tsep_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_is_last (s_is_last),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cmd       (cmd)
    );

    tsep_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .s_char_code     (s_char_code),
        .s_is_last       (s_is_last),
        .m_epoch_seconds (m_epoch_seconds),
        .m_status        (m_status)
    );

endmodule

`default_nettype wire
